// ----- rtl/tlbpt_pkg.sv -----
package tlbpt_pkg;

   // fixed field widths of the transaction ports
   localparam int ADDR_WIDTH      = 16;
   localparam int PHYS_ADDR_WIDTH = 15;
   localparam int FRAME_OUT_WIDTH = 7;
   localparam int OUTCOME_WIDTH   = 2;

   // default geometry
   localparam int DEF_TLB_ENTRIES = 16;
   localparam int DEF_PAGE_COUNT  = 256;
   localparam int DEF_FRAME_COUNT = 128;
   localparam int DEF_OFFSET_BITS = 8;

   typedef enum logic [OUTCOME_WIDTH-1:0] {
      OUTCOME_TLB_HIT = 2'd0,
      OUTCOME_PT_HIT  = 2'd1,
      OUTCOME_FAULT   = 2'd2
   } outcome_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP
   } state_type;

endpackage

// ----- rtl/tlb_page_table_translator.sv -----
// Translates one 16-bit logical address per transaction into a physical address. The address
// splits into a page number (upper bits) and a byte offset (low OFFSET_BITS bits). A fully
// associative TLB of TLB_ENTRIES entries, held in flip-flops and compared in parallel, is
// searched first (lowest matching entry wins), then a PAGE_COUNT-entry page table in a
// synchronous memory. When both miss, the next frame from a round-robin counter that wraps at
// FRAME_COUNT is written into the page table and into the TLB slot named by a FIFO pointer; a
// page table hit does not fill the TLB, and a reused frame does not invalidate older mappings.
// A transaction is accepted in the idle state, which issues the page table read, and is then
// decided and written back in the lookup state; no new address is taken during the lookup. A
// finished result sits in an output register, so the next address is taken while it waits.
// After reset a clearing pass marks all PAGE_COUNT page table entries invalid; req_stall stays
// high until it ends. PAGE_COUNT must be a power of two (the page number is reduced modulo it).
module tlb_page_table_translator #(
   parameter int TLB_ENTRIES = tlbpt_pkg::DEF_TLB_ENTRIES,
   parameter int PAGE_COUNT  = tlbpt_pkg::DEF_PAGE_COUNT,
   parameter int FRAME_COUNT = tlbpt_pkg::DEF_FRAME_COUNT,
   parameter int OFFSET_BITS = tlbpt_pkg::DEF_OFFSET_BITS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // request channel
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [tlbpt_pkg::ADDR_WIDTH-1:0]       req_logical_address,
   // response channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [tlbpt_pkg::PHYS_ADDR_WIDTH-1:0]  rsp_phys_addr,
   output logic [tlbpt_pkg::FRAME_OUT_WIDTH-1:0]  rsp_frame_used,
   output logic [tlbpt_pkg::OUTCOME_WIDTH-1:0]    rsp_outcome
);
   import tlbpt_pkg::*;

   localparam int PAGE_BITS    = $clog2(PAGE_COUNT);
   localparam int FRAME_BITS   = $clog2(FRAME_COUNT);
   localparam int TLB_IDX_BITS = $clog2(TLB_ENTRIES);

   localparam logic [PAGE_BITS-1:0]    LAST_PAGE  = PAGE_BITS'(PAGE_COUNT - 1);
   localparam logic [FRAME_BITS-1:0]   LAST_FRAME = FRAME_BITS'(FRAME_COUNT - 1);
   localparam logic [TLB_IDX_BITS-1:0] LAST_SLOT  = TLB_IDX_BITS'(TLB_ENTRIES - 1);

   // control state
   state_type                state_ff, state_in;
   logic [PAGE_BITS-1:0]     clr_idx_ff;
   logic [FRAME_BITS-1:0]    next_free_ff;
   logic [TLB_IDX_BITS-1:0]  fill_ptr_ff;
   logic [TLB_ENTRIES-1:0]   tlb_valid_ff;
   logic                     rsp_valid_ff;

   // tlb contents
   logic [PAGE_BITS-1:0]     tlb_tag_ff   [TLB_ENTRIES];
   logic [FRAME_BITS-1:0]    tlb_frame_ff [TLB_ENTRIES];

   // page table memory: valid bit over frame number
   logic [FRAME_BITS:0]      page_mem [PAGE_COUNT];
   logic [FRAME_BITS:0]      pm_rd_ff;

   // transaction in flight
   logic [PAGE_BITS-1:0]     page_ff;
   logic [OFFSET_BITS-1:0]   offset_ff;

   // response registers
   logic [PHYS_ADDR_WIDTH-1:0] rsp_phys_ff;
   logic [FRAME_OUT_WIDTH-1:0] rsp_frame_ff;
   outcome_type                rsp_outcome_ff;

   // control strobes
   logic                     req_accept;
   logic                     out_free;
   logic                     load_out;
   logic                     do_fault;
   logic                     clr_we;

   // lookup results
   logic                     tlb_hit;
   logic [FRAME_BITS-1:0]    tlb_hit_frame;
   logic                     pm_valid;
   logic [FRAME_BITS-1:0]    pm_frame;
   logic [FRAME_BITS-1:0]    sel_frame;
   outcome_type              sel_outcome;

   // page table write port
   logic                     pm_we;
   logic [PAGE_BITS-1:0]     pm_wa;
   logic [FRAME_BITS:0]      pm_wd;

   logic [PAGE_BITS-1:0]     req_page;

   // page number reduced modulo the table size
   assign req_page   = PAGE_BITS'(req_logical_address >> OFFSET_BITS);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // ---------------------------------------------------------------------------
   // sequencer: clearing pass, then accept / lookup alternating
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_stall = 1'b1;
      load_out  = 1'b0;
      do_fault  = 1'b0;
      clr_we    = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_we = 1'b1;
            if (clr_idx_ff == LAST_PAGE) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            // hold the decision until the output register can take it
            if (out_free) begin
               load_out = 1'b1;
               do_fault = !tlb_hit && !pm_valid;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // clearing pass address
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_idx_ff <= '0;
      end else if (clr_we) begin
         clr_idx_ff <= clr_idx_ff + 1'b1;
      end
   end

   // capture the transaction
   always_ff @(posedge clock) begin
      if (req_accept) begin
         page_ff   <= req_page;
         offset_ff <= req_logical_address[OFFSET_BITS-1:0];
      end
   end

   // ---------------------------------------------------------------------------
   // page table memory, read on accept, written by the clearing pass or a fault
   // ---------------------------------------------------------------------------
   assign pm_we = clr_we || do_fault;
   assign pm_wa = clr_we ? clr_idx_ff : page_ff;
   assign pm_wd = clr_we ? '0 : {1'b1, next_free_ff};

   always_ff @(posedge clock) begin
      if (pm_we) begin
         page_mem[pm_wa] <= pm_wd;
      end
      if (req_accept) begin
         pm_rd_ff <= page_mem[req_page];
      end
   end

   assign pm_valid = pm_rd_ff[FRAME_BITS];
   assign pm_frame = pm_rd_ff[FRAME_BITS-1:0];

   // ---------------------------------------------------------------------------
   // tlb search: parallel compare, lowest matching entry wins
   // ---------------------------------------------------------------------------
   always_comb begin
      tlb_hit       = 1'b0;
      tlb_hit_frame = '0;
      for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
         if (tlb_valid_ff[i] && (tlb_tag_ff[i] == page_ff)) begin
            tlb_hit       = 1'b1;
            tlb_hit_frame = tlb_frame_ff[i];
         end
      end
   end

   always_comb begin
      if (tlb_hit) begin
         sel_frame   = tlb_hit_frame;
         sel_outcome = OUTCOME_TLB_HIT;
      end else if (pm_valid) begin
         sel_frame   = pm_frame;
         sel_outcome = OUTCOME_PT_HIT;
      end else begin
         sel_frame   = next_free_ff;
         sel_outcome = OUTCOME_FAULT;
      end
   end

   // fault: fill the fifo slot, advance the frame counter
   always_ff @(posedge clock) begin
      if (reset) begin
         tlb_valid_ff <= '0;
         fill_ptr_ff  <= '0;
         next_free_ff <= '0;
      end else if (do_fault) begin
         tlb_valid_ff[fill_ptr_ff] <= 1'b1;
         fill_ptr_ff  <= (fill_ptr_ff == LAST_SLOT) ? '0 : fill_ptr_ff + 1'b1;
         next_free_ff <= (next_free_ff == LAST_FRAME) ? '0 : next_free_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_fault) begin
         tlb_tag_ff[fill_ptr_ff]   <= page_ff;
         tlb_frame_ff[fill_ptr_ff] <= next_free_ff;
      end
   end

   // ---------------------------------------------------------------------------
   // output register
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_phys_ff    <= PHYS_ADDR_WIDTH'({sel_frame, offset_ff});
         rsp_frame_ff   <= FRAME_OUT_WIDTH'(sel_frame);
         rsp_outcome_ff <= sel_outcome;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_phys_addr  = rsp_phys_ff;
   assign rsp_frame_used = rsp_frame_ff;
   assign rsp_outcome    = rsp_outcome_ff;

   // ---------------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------------
   a_accept_to_lookup: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ST_LOOKUP))
      else $error("accepted transaction did not enter lookup");

   a_fault_fills_tlb: assert property (@(posedge clock) disable iff (reset)
      do_fault |=> tlb_valid_ff[$past(fill_ptr_ff)] &&
                   (tlb_tag_ff[$past(fill_ptr_ff)] == $past(page_ff)))
      else $error("fault did not fill the tlb slot");

   a_tlb_hit_outcome: assert property (@(posedge clock) disable iff (reset)
      (load_out && tlb_hit) |=> rsp_valid && (rsp_outcome == OUTCOME_TLB_HIT))
      else $error("tlb hit reported with wrong outcome");

endmodule
